// ===== design/b64d_pkg.sv =====
package b64d_pkg;

  localparam int CHAR_W   = 8;
  localparam int SEXTET_W = 6;
  localparam int ACC_W    = 24;
  localparam int PADS_W   = 3;
  localparam int COUNT_W  = 2;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    KIND_SKIP   = 2'd0,
    KIND_SEXTET = 2'd1,
    KIND_PAD    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [SEXTET_W-1:0]   sextet;
    logic                  last;
  } entry_t;

endpackage

// ===== design/b64d_front.sv =====
module b64d_front (
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [b64d_pkg::CHAR_W-1:0] in_tdata,  // in_char
  input  logic                        in_tlast,  // is_final
  input  logic                        q_full,
  output logic                        push,
  output b64d_pkg::entry_t            push_entry
);

  b64d_pkg::kind_t                 kind;
  logic [b64d_pkg::SEXTET_W-1:0]   sextet;
  logic [b64d_pkg::CHAR_W-1:0]     ch;

  always_comb begin
    ch     = in_tdata;
    kind   = b64d_pkg::KIND_SEXTET;
    sextet = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      sextet = b64d_pkg::SEXTET_W'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      sextet = b64d_pkg::SEXTET_W'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      sextet = b64d_pkg::SEXTET_W'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      sextet = 6'd62;
    end else if (ch == 8'h2F) begin
      sextet = 6'd63;
    end else if (ch == b64d_pkg::PAD_CHAR) begin
      kind = b64d_pkg::KIND_PAD;
    end else begin
      kind = b64d_pkg::KIND_SKIP;
    end
  end

  // skipped characters only travel when they close a message
  assign in_tready = !q_full;
  assign push = in_tvalid && in_tready && (kind != b64d_pkg::KIND_SKIP || in_tlast);

  assign push_entry.kind   = kind;
  assign push_entry.sextet = sextet;
  assign push_entry.last   = in_tlast;

endmodule

// ===== design/b64d_queue.sv =====
module b64d_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64d_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output b64d_pkg::entry_t pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64d_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/b64d_back.sv =====
module b64d_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  b64d_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // first_byte, second_byte, third_byte, byte_count
  output logic             out_tlast   // end_of_message
);

  logic [b64d_pkg::ACC_W-1:0]    acc;
  logic [1:0]                    held;
  logic [b64d_pkg::PADS_W-1:0]   pad_seen;
  logic                          stopped;

  logic [7:0]                    first_byte;
  logic [7:0]                    second_byte;
  logic [7:0]                    third_byte;
  logic [b64d_pkg::COUNT_W-1:0]  byte_count;
  logic                          end_of_message;

  logic                          take;
  logic                          is_pad;
  logic [b64d_pkg::SEXTET_W-1:0] sx;
  logic [b64d_pkg::ACC_W-1:0]    acc_sh;
  logic [b64d_pkg::PADS_W-1:0]   pads_inc;
  logic                          group_full;
  logic [1:0]                    held_after;
  logic [b64d_pkg::ACC_W-1:0]    acc_after;
  logic [b64d_pkg::PADS_W-1:0]   pads_after;
  logic [b64d_pkg::ACC_W-1:0]    fin_acc;
  logic [b64d_pkg::PADS_W-1:0]   fin_pads;
  logic                          emit;
  logic [b64d_pkg::ACC_W-1:0]    emit_acc;
  logic [b64d_pkg::PADS_W-1:0]   emit_pads;
  logic [b64d_pkg::COUNT_W-1:0]  emit_count;

  assign q_pop = q_valid && (!out_tvalid || out_tready);

  always_comb begin
    is_pad     = (q_entry.kind == b64d_pkg::KIND_PAD);
    take       = !stopped && (q_entry.kind != b64d_pkg::KIND_SKIP);
    sx         = is_pad ? '0 : q_entry.sextet;
    acc_sh     = {acc[b64d_pkg::ACC_W-b64d_pkg::SEXTET_W-1:0], sx};
    pads_inc   = pad_seen + b64d_pkg::PADS_W'(is_pad);
    group_full = take && (held == 2'd3);
    held_after = take ? held + 2'd1 : held;
    acc_after  = take ? acc_sh : acc;
    pads_after = take ? pads_inc : pad_seen;

    // partial group at message end: pad out with zero sextets
    unique case (held_after)
      2'd1:    fin_acc = {acc_after[5:0], 18'd0};
      2'd2:    fin_acc = {acc_after[11:0], 12'd0};
      2'd3:    fin_acc = {acc_after[17:0], 6'd0};
      default: fin_acc = '0;
    endcase
    fin_pads = pads_after + 3'd4 - {1'b0, held_after};

    emit      = group_full || q_entry.last;
    emit_acc  = group_full ? acc_sh : fin_acc;
    emit_pads = group_full ? pads_inc : fin_pads;

    unique case (emit_pads)
      3'd0:    emit_count = 2'd3;
      3'd1:    emit_count = 2'd2;
      3'd2:    emit_count = 2'd1;
      default: emit_count = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      held     <= '0;
      pad_seen <= '0;
      stopped  <= 1'b0;
    end else if (q_pop) begin
      if (q_entry.last || group_full) begin
        acc      <= '0;
        held     <= '0;
        pad_seen <= '0;
        stopped  <= !q_entry.last && (pads_inc != '0);
      end else if (take) begin
        acc      <= acc_sh;
        held     <= held + 2'd1;
        pad_seen <= pads_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tvalid <= 1'b0;
    end else if (q_pop && emit) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      first_byte     <= (emit_count >= 2'd1) ? emit_acc[23:16] : 8'd0;
      second_byte    <= (emit_count >= 2'd2) ? emit_acc[15:8] : 8'd0;
      third_byte     <= (emit_count == 2'd3) ? emit_acc[7:0] : 8'd0;
      byte_count     <= emit_count;
      end_of_message <= q_entry.last;
    end
  end

  assign out_tdata = {6'd0, byte_count, third_byte, second_byte, first_byte};
  assign out_tlast = end_of_message;

  a_unused_bytes_zero: assert property (@(posedge clk) disable iff (rst)
    out_tvalid |-> (byte_count == 2'd3 || third_byte == 8'd0) &&
                   (byte_count >= 2'd2 || second_byte == 8'd0) &&
                   (byte_count >= 2'd1 || first_byte == 8'd0))
    else $error("byte beyond count not zero");
  a_stopped_empty_group: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (held == 2'd0 && pad_seen == '0))
    else $error("group state held while stopped");
  a_pads_within_group: assert property (@(posedge clk) disable iff (rst)
    pad_seen <= {1'b0, held})
    else $error("more pads than sextets in group");

endmodule

// ===== design/base64_stream_decoder.sv =====
// Base64 decoder for the standard alphabet, one character per item. Characters outside
// A-Z a-z 0-9 + / and '=' are dropped; '=' stands for a zero sextet and counts as a pad.
// Every fourth sextet gives one result with 3, 2, 1 or 0 bytes for 0, 1, 2 or more pads,
// and after a padded group the rest of the message is ignored. The item flagged with tlast
// always gives one result with tlast set, completing a partial group with padding (byte
// count 0 if nothing is pending). One item is taken every cycle while the output is taken;
// an item passes the classifier into a QUEUE_DEPTH-entry queue, and any result is registered
// in the output register when the back end pops that item from the queue.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_char
  input  logic        in_tlast,   // is_final
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // first_byte, second_byte, third_byte, byte_count
  output logic        out_tlast   // end_of_message
);

  logic             push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  b64d_pkg::entry_t push_entry;
  b64d_pkg::entry_t q_entry;

  b64d_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/base64_stream_decoder_tb.sv =====
module base64_stream_decoder_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_ITEMS = 950;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [1:0] byte_count;
    logic       end_of_message;
  } group_t;

  class group_scoreboard;
    bit [b64d_pkg::ACC_W-1:0]   acc;
    bit [b64d_pkg::COUNT_W-1:0] held;
    bit [b64d_pkg::PADS_W-1:0]  pads;
    bit                         stopped;
    group_t                     expected_groups[$];
    int                         errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      acc     = '0;
      held    = '0;
      pads    = '0;
      stopped = 1'b0;
    endfunction

    function int sextet_of(logic [7:0] ch);
      if (ch >= 8'h41 && ch <= 8'h5A) return int'(ch) - 'h41;
      if (ch >= 8'h61 && ch <= 8'h7A) return int'(ch) - 'h61 + 26;
      if (ch >= 8'h30 && ch <= 8'h39) return int'(ch) - 'h30 + 52;
      if (ch == 8'h2B) return 62;
      if (ch == 8'h2F) return 63;
      return -1;
    endfunction

    function group_t make_group(bit [b64d_pkg::ACC_W-1:0] a, int p, bit eom);
      group_t g;
      int n;
      n = (p == 0) ? 3 : (p == 1) ? 2 : (p == 2) ? 1 : 0;
      g.first_byte     = (n >= 1) ? a[23:16] : 8'h00;
      g.second_byte    = (n >= 2) ? a[15:8] : 8'h00;
      g.third_byte     = (n >= 3) ? a[7:0] : 8'h00;
      g.byte_count     = n[1:0];
      g.end_of_message = eom;
      return g;
    endfunction

    function void note_char(logic [7:0] ch, logic fin);
      int sx;
      bit produced;
      bit [b64d_pkg::ACC_W-1:0] a;
      int p;
      produced = 1'b0;
      sx = -1;
      if (!stopped) begin
        if (ch == b64d_pkg::PAD_CHAR) begin
          sx = 0;
          pads++;
        end else begin
          sx = sextet_of(ch);
        end
        if (sx >= 0) begin
          acc = {acc[17:0], sx[5:0]};
          if (held == 2'd3) begin
            expected_groups.push_back(make_group(acc, int'(pads), fin));
            produced = 1'b1;
            if (pads != 0) stopped = 1'b1;
            acc  = '0;
            held = '0;
            pads = '0;
          end else begin
            held++;
          end
        end
      end
      if (fin) begin
        if (!produced) begin
          // partial or empty group is filled with zero sextets, each a pad
          a = acc;
          p = int'(pads);
          for (int k = int'(held); k < 4; k++) begin
            a = a << 6;
            p++;
          end
          expected_groups.push_back(make_group(a, p, 1'b1));
        end
        clear();
      end
    endfunction

    function void compare_field(string name, logic [7:0] expv, logic [7:0] act);
      if (act !== expv) begin
        $error("%s expected %0h actual %0h", name, expv, act);
        errors++;
      end
    endfunction

    function void check_group(logic [31:0] data, logic last);
      group_t g;
      if (expected_groups.size() == 0) begin
        $error("result with nothing expected: tdata %0h tlast %0b", data, last);
        errors++;
        return;
      end
      g = expected_groups.pop_front();
      compare_field("first_byte", g.first_byte, data[7:0]);
      compare_field("second_byte", g.second_byte, data[15:8]);
      compare_field("third_byte", g.third_byte, data[23:16]);
      compare_field("byte_count", {6'd0, g.byte_count}, {6'd0, data[25:24]});
      compare_field("tdata padding", 8'h00, {2'd0, data[31:26]});
      compare_field("end_of_message", {7'd0, g.end_of_message}, {7'd0, last});
    endfunction

    function int num_waiting();
      return expected_groups.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // in_char
  logic        in_tlast = 1'b0;    // is_final
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // first_byte, second_byte, third_byte, byte_count
  logic        out_tlast;          // end_of_message

  group_scoreboard sb;
  logic [7:0]      message_chars[$];
  int              items_sent = 0;
  int              tx_max_gap = 8;
  int              rx_max_stall = 8;
  int              cycles = 0;

  base64_stream_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_stream_decoder: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] b64_char(int v);
    if (v < 26) return 8'(v + 'h41);
    if (v < 52) return 8'(v + 'h61 - 26);
    if (v < 62) return 8'(v + 'h30 - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (sb.sextet_of(c) >= 0 || c == b64d_pkg::PAD_CHAR) c = 8'h0A;
    return c;
  endfunction

  task automatic send_char(logic [7:0] ch, logic fin);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_char(ch, fin);
    items_sent++;
  endtask

  task automatic send_text(string s, logic fin);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic send_message();
    for (int i = 0; i < message_chars.size(); i++)
      send_char(message_chars[i], i == message_chars.size() - 1);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.num_waiting() > 0);
  endtask

  task automatic build_encoded();
    int nbytes;
    int left;
    bit drop_pad;
    logic [23:0] chunk;
    message_chars.delete();
    nbytes = $urandom_range(0, 14);
    drop_pad = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nbytes; i += 3) begin
      left = nbytes - i;
      chunk = 24'($urandom);
      if (left < 3) chunk[7:0] = 8'h00;
      if (left < 2) chunk[15:8] = 8'h00;
      for (int s = 0; s < 4; s++) begin
        if (s >= left + 1) begin
          if (!drop_pad) message_chars.push_back(b64d_pkg::PAD_CHAR);
        end else begin
          message_chars.push_back(b64_char(int'(chunk[23 - 6 * s -: 6])));
        end
        if ($urandom_range(0, 9) == 0) message_chars.push_back(noise_char());
      end
    end
    // trailing text after padding is ignored by the block
    if ($urandom_range(0, 4) == 0) message_chars.push_back(b64_char($urandom_range(0, 63)));
    if (message_chars.size() == 0) message_chars.push_back(noise_char());
  endtask

  task automatic build_noise();
    int n;
    message_chars.delete();
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) message_chars.push_back(b64d_pkg::PAD_CHAR);
      else message_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int stall;
    int seen;
    seen = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (seen == 30 || seen == 150) stall = HOLD_CYCLES;
      else stall = $urandom_range(0, rx_max_stall);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_group(out_tdata, out_tlast);
      seen++;
    end
  end

  initial begin
    int msg_idx;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_text("AZaz09+/", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("T", 1'b1);
    send_text("QQ==AB", 1'b1);
    send_text("A=BC", 1'b1);
    send_char(8'h2A, 1'b1);
    send_text("====", 1'b1);
    pause_until_drained();

    msg_idx = 0;
    while (items_sent < TARGET_ITEMS) begin
      if (msg_idx % 8 == 5) begin
        tx_max_gap   = 0;
        rx_max_stall = 0;
      end else begin
        tx_max_gap   = 8;
        rx_max_stall = 8;
      end
      if ($urandom_range(0, 9) < 7) build_encoded();
      else build_noise();
      send_message();
      if (msg_idx % 25 == 24) pause_until_drained();
      msg_idx++;
    end
    in_tvalid <= 1'b0;

    while (sb.num_waiting() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.num_waiting() == 0) begin
      $display("base64_stream_decoder: match");
    end else begin
      $display("base64_stream_decoder: mismatch");
    end
    $finish;
  end

endmodule
